>>> rtl/tvscs_pkg.sv
// ----------------------------------------------------------------------------
// tvscs_pkg: shared definitions of the three-voice sine chord synth
// sizes, register codes, reset values and the quarter-wave sine/cosine tables
// ----------------------------------------------------------------------------
package tvscs_pkg;

    // sizing
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int VOICE_COUNT      = 3;
    localparam int SAMPLE_BITS      = 24;

    localparam int PHASE_BITS  = 32;
    localparam int GAIN_BITS   = 15;
    localparam int TABLE_BITS  = 24;
    localparam int IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_DEPTH   = SINE_TABLE_DEPTH / 4;
    localparam int QTR_BITS    = IDX_BITS - 2;
    localparam int TW_COUNT    = 3;
    localparam int PROD_BITS   = TABLE_BITS + GAIN_BITS + 1;
    localparam int SUM_BITS    = TABLE_BITS + ((VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 0);
    localparam int WIDE_BITS   = ((SUM_BITS > SAMPLE_BITS) ? SUM_BITS : SAMPLE_BITS) + 1;

    // configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TUNING_A = 4'd0,
        REG_TUNING_B = 4'd1,
        REG_TUNING_C = 4'd2,
        REG_GAIN     = 4'd3
    } cfg_reg_t;

    // reset values: 440 Hz, 554.37 Hz and 659.25 Hz at 44.1 kHz, gain 0.25
    localparam logic [PHASE_BITS-1:0] TUNING_A_RESET = 32'd42852281;
    localparam logic [PHASE_BITS-1:0] TUNING_B_RESET = 32'd53990264;
    localparam logic [PHASE_BITS-1:0] TUNING_C_RESET = 32'd64204840;
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET     = 15'd8192;

    // series constants in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam longint      TABLE_MAX   = 64'sd8388607;

    typedef logic signed [TABLE_BITS-1:0] qtr_rom_t [QTR_DEPTH];

    // truncated taylor series, Q30 in, Q1.23 magnitude out
    function automatic logic signed [TABLE_BITS-1:0] series_q23(
        input logic [63:0] theta,
        input bit          odd
    );
        logic [63:0] t2;
        logic [63:0] term;
        longint      acc;
        logic [63:0] v;
        t2 = (theta * theta) >> 30;
        if (odd) begin
            term = theta;
            acc  = longint'(term);
            term = ((term * t2) >> 30) / 64'd6;   acc = acc - longint'(term);
            term = ((term * t2) >> 30) / 64'd20;  acc = acc + longint'(term);
            term = ((term * t2) >> 30) / 64'd42;  acc = acc - longint'(term);
            term = ((term * t2) >> 30) / 64'd72;  acc = acc + longint'(term);
            term = ((term * t2) >> 30) / 64'd110; acc = acc - longint'(term);
            term = ((term * t2) >> 30) / 64'd156; acc = acc + longint'(term);
            term = ((term * t2) >> 30) / 64'd210; acc = acc - longint'(term);
            term = ((term * t2) >> 30) / 64'd272; acc = acc + longint'(term);
        end
        else begin
            term = ONE_Q30;
            acc  = longint'(term);
            term = ((term * t2) >> 30) / 64'd2;   acc = acc - longint'(term);
            term = ((term * t2) >> 30) / 64'd12;  acc = acc + longint'(term);
            term = ((term * t2) >> 30) / 64'd30;  acc = acc - longint'(term);
            term = ((term * t2) >> 30) / 64'd56;  acc = acc + longint'(term);
            term = ((term * t2) >> 30) / 64'd90;  acc = acc - longint'(term);
            term = ((term * t2) >> 30) / 64'd132; acc = acc + longint'(term);
            term = ((term * t2) >> 30) / 64'd182; acc = acc - longint'(term);
            term = ((term * t2) >> 30) / 64'd240; acc = acc + longint'(term);
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = (64'(acc) + 64'd64) >> 7;
        if (v > 64'(TABLE_MAX)) begin
            v = 64'(TABLE_MAX);
        end
        return v[TABLE_BITS-1:0];
    endfunction

    // one quadrant of sine (odd) or cosine values, built at elaboration
    function automatic qtr_rom_t build_qtr(input bit odd);
        qtr_rom_t    rom;
        logic [63:0] theta;
        for (int j = 0; j < QTR_DEPTH; j++) begin
            theta  = (64'(4 * j) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            rom[j] = series_q23(theta, odd);
        end
        return rom;
    endfunction

    localparam qtr_rom_t SIN_QTR = build_qtr(1'b1);
    localparam qtr_rom_t COS_QTR = build_qtr(1'b0);

endpackage

>>> rtl/three_voice_sine_chord_synth.sv
// ----------------------------------------------------------------------------
// three_voice_sine_chord_synth: three-voice dds sine chord source
//
// Every input beat is one sample tick and gives exactly one output beat, a
// signed 24-bit sample meant for both stereo channels plus a clip flag. Each
// voice has a 32-bit phase accumulator stepped by its tuning word
// (frequency / 44100 * 2^32) after the tick's sample is taken; restart on a
// beat zeroes all phases before that sample. The top 10 phase bits pick a
// sine entry (Q1.23) from two 256-entry quarter-wave tables, the entry is
// scaled by the shared Q0.15 gain with floor rounding, and the voices are
// summed and saturated. The block takes one beat per clock cycle unless the
// output stalls; index, table read, gain multiply and sum and saturate are
// registered in turn, and a stall on the output holds the whole pipeline.
// Registers are written through cfg_we/cfg_index/cfg_wdata and should only
// change while no beat is in flight; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module three_voice_sine_chord_synth
    import tvscs_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          cfg_wdata,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]     mixed_sample,
    output logic                              clipped
);

    localparam logic signed [WIDE_BITS-1:0] SAMPLE_MAX =
        WIDE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_BITS-1:0] SAMPLE_MIN = -SAMPLE_MAX - WIDE_BITS'(1);

    // configuration registers
    logic [TW_COUNT-1:0][PHASE_BITS-1:0]    tw_reg;
    logic [GAIN_BITS-1:0]                   gain_reg;

    // phase state, one accumulator per voice
    logic [VOICE_COUNT-1:0][PHASE_BITS-1:0] phase_reg;
    logic [VOICE_COUNT-1:0][PHASE_BITS-1:0] phase_next;
    logic [VOICE_COUNT-1:0][PHASE_BITS-1:0] phase_base;
    logic [VOICE_COUNT-1:0][PHASE_BITS-1:0] tw_voice;

    // pipeline: table index, table entry, scaled voice, output
    logic [VOICE_COUNT-1:0][IDX_BITS-1:0]   idx_reg;
    logic [VOICE_COUNT-1:0][IDX_BITS-1:0]   idx_next;
    logic [VOICE_COUNT-1:0][TABLE_BITS-1:0] entry_reg;
    logic [VOICE_COUNT-1:0][TABLE_BITS-1:0] entry_next;
    logic [VOICE_COUNT-1:0][TABLE_BITS-1:0] scaled_reg;
    logic [VOICE_COUNT-1:0][TABLE_BITS-1:0] scaled_next;
    logic signed [SAMPLE_BITS-1:0]          mixed_reg;
    logic signed [SAMPLE_BITS-1:0]          mixed_next;
    logic                                   clip_reg;
    logic                                   clip_next;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    logic advance;
    logic accept;

    // whole pipeline moves unless a finished beat is held at the output
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    // voices past the third have no tuning word and stay at phase zero
    always_comb
    begin
        for (int v = 0; v < VOICE_COUNT; v++) begin
            if (v < TW_COUNT) begin
                tw_voice[v] = tw_reg[v];
            end
            else begin
                tw_voice[v] = '0;
            end
        end
    end

    // restart clears the phase before this tick's sample; step after sampling
    always_comb
    begin
        for (int v = 0; v < VOICE_COUNT; v++) begin
            phase_base[v] = restart ? '0 : phase_reg[v];
            phase_next[v] = phase_base[v] + tw_voice[v];
            idx_next[v]   = phase_base[v][PHASE_BITS-1 -: IDX_BITS];
        end
    end

    // quarter-wave lookup: quadrant bit 0 picks cosine, bit 1 negates
    always_comb
    begin
        logic [1:0]                    quad;
        logic [QTR_BITS-1:0]           pos;
        logic signed [TABLE_BITS-1:0]  mag;
        quad = '0;
        pos  = '0;
        mag  = '0;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            quad = idx_reg[v][IDX_BITS-1 -: 2];
            pos  = idx_reg[v][QTR_BITS-1:0];
            mag  = quad[0] ? COS_QTR[pos] : SIN_QTR[pos];
            entry_next[v] = quad[1] ? -mag : mag;
        end
    end

    // gain scaling, arithmetic shift gives floor rounding
    always_comb
    begin
        logic signed [PROD_BITS-1:0] prod;
        prod = '0;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            prod = $signed(entry_reg[v]) * $signed({1'b0, gain_reg});
            scaled_next[v] = TABLE_BITS'(prod >>> GAIN_BITS);
        end
    end

    // mix and saturate
    always_comb
    begin
        logic signed [WIDE_BITS-1:0] acc;
        acc = '0;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            acc = acc + WIDE_BITS'($signed(scaled_reg[v]));
        end
        if (acc > SAMPLE_MAX) begin
            mixed_next = SAMPLE_MAX[SAMPLE_BITS-1:0];
            clip_next  = 1'b1;
        end
        else if (acc < SAMPLE_MIN) begin
            mixed_next = SAMPLE_MIN[SAMPLE_BITS-1:0];
            clip_next  = 1'b1;
        end
        else begin
            mixed_next = acc[SAMPLE_BITS-1:0];
            clip_next  = 1'b0;
        end
    end

    // control state: registers, phases, beat valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tw_reg[0]     <= TUNING_A_RESET;
            tw_reg[1]     <= TUNING_B_RESET;
            tw_reg[2]     <= TUNING_C_RESET;
            gain_reg      <= GAIN_RESET;
            phase_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TUNING_A: tw_reg[0] <= cfg_wdata[PHASE_BITS-1:0];
                    REG_TUNING_B: tw_reg[1] <= cfg_wdata[PHASE_BITS-1:0];
                    REG_TUNING_C: tw_reg[2] <= cfg_wdata[PHASE_BITS-1:0];
                    REG_GAIN:     gain_reg  <= cfg_wdata[GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                phase_reg <= phase_next;
            end
            if (advance) begin
                s1_valid_reg  <= in_valid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (advance) begin
            idx_reg    <= idx_next;
            entry_reg  <= entry_next;
            scaled_reg <= scaled_next;
            mixed_reg  <= mixed_next;
            clip_reg   <= clip_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = mixed_reg;
    assign clipped      = clip_reg;

    // restart beat leaves each phase at exactly one tuning step; checked on voice 0
    a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |=> phase_reg[0] == $past(tw_voice[0]))
        else $error("phase after restart is not one tuning step");

    // phases only move on an accepted beat
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg))
        else $error("phase changed without an input beat");

    // a clipped beat carries a full-scale value
    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && clip_reg |->
            (mixed_reg == SAMPLE_MAX[SAMPLE_BITS-1:0]) ||
            (mixed_reg == SAMPLE_MIN[SAMPLE_BITS-1:0]))
        else $error("clip flag without a saturated sample");

    // an output beat appears only from the last pipeline stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s3_valid_reg))
        else $error("output beat without a beat in the last stage");

endmodule
